// ===== rtl/core/erj_pkg.sv =====
// erj_pkg: shared field widths, operation codes and sizing defaults for the event ring journal
// no dependencies; used by event_ring_journal_top and the testbench
package erj_pkg;

    // default sizing of the ring
    localparam int CAPACITY         = 200;
    localparam int EVENTS_PER_BLOCK = 10;

    // event types 1 to MAX_KIND are legal
    localparam int MAX_KIND = 14;

    // item field widths
    localparam int FUNC_W  = 2;
    localparam int SEQ_W   = 32;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 8;
    localparam int PARAM_W = 8;
    localparam int BLOCK_W = 5;
    localparam int COUNT_W = 8;

    // one stored entry: time, kind, param
    localparam int ENTRY_W = TIME_W + KIND_W + PARAM_W;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TAKE   = 2'd2;

endpackage

// ===== rtl/core/erj_ram.sv =====
// erj_ram: generic single write port, single read port ram with registered read data
// no dependencies
module erj_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 200
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/erj_pick.sv =====
// erj_pick: lowest-set-bit priority encoder over the dirty block marks
// no dependencies
module erj_pick #(
    parameter int N     = 20,
    parameter int IDX_W = 5
) (
    input  logic [N-1:0]     i_bits,
    output logic             o_found,
    output logic [IDX_W-1:0] o_index
);

    // scan from the top so the lowest set bit wins
    always_comb begin
        o_index = '0;
        for (int b = N - 1; b >= 0; b--) begin
            if (i_bits[b]) begin
                o_index = IDX_W'(b);
            end
        end
    end

    assign o_found = |i_bits;

endmodule

// ===== rtl/core/event_ring_journal_top.sv =====
// event_ring_journal_top: sequenced ring log of events grouped into dirty-tracked blocks
// depends on erj_pkg, erj_ram (entry store) and erj_pick (lowest dirty block)
// each accepted item's result is registered; throughput: one item per cycle while the result side does not stall
// the entry store ram has one write and one read port, one access per item sets the rate
// reset (synchronous, active low) empties the log and clears all dirty marks at once
// the entry store itself is not cleared: only retained, already written entries are read
module event_ring_journal_top #(
    parameter int CAPACITY         = erj_pkg::CAPACITY,
    parameter int EVENTS_PER_BLOCK = erj_pkg::EVENTS_PER_BLOCK
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [erj_pkg::FUNC_W-1:0]   i_func,
    input  logic [erj_pkg::SEQ_W-1:0]    i_seq_number,
    input  logic [erj_pkg::TIME_W-1:0]   i_event_time,
    input  logic [erj_pkg::KIND_W-1:0]   i_event_kind,
    input  logic [erj_pkg::PARAM_W-1:0]  i_event_param,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ok,
    output logic [erj_pkg::TIME_W-1:0]   o_read_time,
    output logic [erj_pkg::KIND_W-1:0]   o_read_kind,
    output logic [erj_pkg::PARAM_W-1:0]  o_read_param,
    output logic [erj_pkg::BLOCK_W-1:0]  o_flushed_block,
    output logic [erj_pkg::COUNT_W-1:0]  o_stored_count,
    output logic [erj_pkg::SEQ_W-1:0]    o_next_seq,
    output logic                         o_work_pending
);

    localparam int BLOCK_COUNT = (CAPACITY + EVENTS_PER_BLOCK - 1) / EVENTS_PER_BLOCK;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int BLK_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int OFF_W       = (EVENTS_PER_BLOCK > 1) ? $clog2(EVENTS_PER_BLOCK) : 1;
    localparam int SEQ_W       = erj_pkg::SEQ_W;
    localparam int ENTRY_W     = erj_pkg::ENTRY_W;
    localparam int KIND_W      = erj_pkg::KIND_W;
    localparam int PARAM_W     = erj_pkg::PARAM_W;

    // log state
    logic [SEQ_W-1:0]       r_last_seq,  n_last_seq;
    logic [CNT_W-1:0]       r_fill,      n_fill;
    logic [SLOT_W-1:0]      r_head_slot, n_head_slot;
    logic [BLK_W-1:0]       r_head_blk,  n_head_blk;
    logic [OFF_W-1:0]       r_head_off,  n_head_off;
    logic [BLOCK_COUNT-1:0] r_dirty,     n_dirty;

    // result register
    logic                   r_ov;
    logic                   r_ok;
    logic                   r_hit;
    logic [BLK_W-1:0]       r_fb;
    logic [CNT_W-1:0]       r_count;
    logic [SEQ_W-1:0]       r_next;
    logic                   r_pend;

    logic                   accept;
    logic [SEQ_W-1:0]       expected;
    logic [SEQ_W-1:0]       n_expected;
    logic                   kind_legal;
    logic                   app_ok;
    logic [SLOT_W-1:0]      app_slot;
    logic [BLK_W-1:0]       app_blk;
    logic [OFF_W-1:0]       app_off;
    logic [SEQ_W-1:0]       rd_dist;
    logic                   rd_ok;
    logic [SLOT_W-1:0]      rd_back;
    logic [SLOT_W:0]        rd_wide;
    logic [SLOT_W-1:0]      rd_slot;
    logic                   pick_found;
    logic [BLK_W-1:0]       pick_index;
    logic                   take_ok;
    logic                   op_ok;
    logic [ENTRY_W-1:0]     ram_q;

    // handshake: one result register, refilled as it drains
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_ov && i_out_stall;

    // next expected sequence, zero once the sequence has wrapped
    assign expected = (r_last_seq == '0) ? SEQ_W'(1) : r_last_seq + SEQ_W'(1);

    // append check
    assign kind_legal = (i_event_kind >= KIND_W'(1)) &&
                        (i_event_kind <= KIND_W'(erj_pkg::MAX_KIND));
    assign app_ok     = (i_func == erj_pkg::FUNC_APPEND) && (i_seq_number != '0) &&
                        kind_legal && (expected != '0) && (i_seq_number == expected);

    // append slot follows the head, so block and offset are tracked by counting
    always_comb begin
        if (r_last_seq == '0 || r_head_slot == SLOT_W'(CAPACITY - 1)) begin
            app_slot = '0;
            app_blk  = '0;
            app_off  = '0;
        end else if (r_head_off == OFF_W'(EVENTS_PER_BLOCK - 1)) begin
            app_slot = r_head_slot + SLOT_W'(1);
            app_blk  = r_head_blk + BLK_W'(1);
            app_off  = '0;
        end else begin
            app_slot = r_head_slot + SLOT_W'(1);
            app_blk  = r_head_blk;
            app_off  = r_head_off + OFF_W'(1);
        end
    end

    // read check: the sequence must lie within the newest fill entries
    assign rd_dist = r_last_seq - i_seq_number;
    assign rd_ok   = (i_func == erj_pkg::FUNC_READ) && (i_seq_number != '0) &&
                     (r_fill != '0) && (i_seq_number <= r_last_seq) &&
                     (rd_dist < SEQ_W'(r_fill));

    // read slot counted back from the head, wrapping around the ring
    assign rd_back = rd_dist[SLOT_W-1:0];
    assign rd_wide = (r_head_slot >= rd_back) ?
                     ({1'b0, r_head_slot} - {1'b0, rd_back}) :
                     ({1'b0, r_head_slot} + (SLOT_W + 1)'(CAPACITY) - {1'b0, rd_back});
    assign rd_slot = rd_wide[SLOT_W-1:0];

    // lowest dirty block
    erj_pick #(
        .N     (BLOCK_COUNT),
        .IDX_W (BLK_W)
    ) u_pick (
        .i_bits  (r_dirty),
        .o_found (pick_found),
        .o_index (pick_index)
    );

    assign take_ok = (i_func == erj_pkg::FUNC_TAKE) && pick_found;

    // next state of the log
    always_comb begin
        n_last_seq  = r_last_seq;
        n_fill      = r_fill;
        n_head_slot = r_head_slot;
        n_head_blk  = r_head_blk;
        n_head_off  = r_head_off;
        n_dirty     = r_dirty;
        op_ok       = 1'b0;
        case (i_func)
            erj_pkg::FUNC_APPEND: begin
                if (app_ok) begin
                    n_last_seq       = i_seq_number;
                    n_head_slot      = app_slot;
                    n_head_blk       = app_blk;
                    n_head_off       = app_off;
                    n_dirty[app_blk] = 1'b1;
                    if (r_fill < CNT_W'(CAPACITY)) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                    op_ok = 1'b1;
                end
            end
            erj_pkg::FUNC_READ: begin
                op_ok = rd_ok;
            end
            erj_pkg::FUNC_TAKE: begin
                if (take_ok) begin
                    n_dirty[pick_index] = 1'b0;
                    op_ok               = 1'b1;
                end
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign n_expected = (n_last_seq == '0) ? SEQ_W'(1) : n_last_seq + SEQ_W'(1);

    // entry store
    erj_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && app_ok),
        .i_waddr (app_slot),
        .i_wdata ({i_event_time, i_event_kind, i_event_param}),
        .i_re    (accept),
        .i_raddr (rd_slot),
        .o_rdata (ram_q)
    );

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq  <= '0;
            r_fill      <= '0;
            r_head_slot <= '0;
            r_head_blk  <= '0;
            r_head_off  <= '0;
            r_dirty     <= '0;
            r_ov        <= 1'b0;
            r_ok        <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            if (accept) begin
                r_last_seq  <= n_last_seq;
                r_fill      <= n_fill;
                r_head_slot <= n_head_slot;
                r_head_blk  <= n_head_blk;
                r_head_off  <= n_head_off;
                r_dirty     <= n_dirty;
                r_ov        <= 1'b1;
                r_ok        <= op_ok;
                r_hit       <= rd_ok;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fb    <= take_ok ? pick_index : '0;
            r_count <= n_fill;
            r_next  <= n_expected;
            r_pend  <= |n_dirty;
        end
    end

    // result ports; read data comes from the store's output register
    assign o_out_valid     = r_ov;
    assign o_ok            = r_ok;
    assign o_read_time     = r_hit ? ram_q[ENTRY_W-1 -: erj_pkg::TIME_W] : '0;
    assign o_read_kind     = r_hit ? ram_q[PARAM_W +: KIND_W] : '0;
    assign o_read_param    = r_hit ? ram_q[PARAM_W-1:0] : '0;
    assign o_flushed_block = erj_pkg::BLOCK_W'(r_fb);
    assign o_stored_count  = erj_pkg::COUNT_W'(r_count);
    assign o_next_seq      = r_next;
    assign o_work_pending  = r_pend;

    // fill count never passes the ring size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // a log with no newest sequence holds no entries
    a_empty_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_seq == '0) |-> (r_fill == '0))
        else $error("entries retained with no sequence");

    // head offset and block stay within their ranges
    a_head_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_off < OFF_W'(EVENTS_PER_BLOCK)) && (r_head_blk < BLK_W'(BLOCK_COUNT)))
        else $error("head block position out of range");

    // a legal accepted append always leaves work pending
    a_append_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && app_ok) |=> (r_pend && r_ok))
        else $error("append did not mark a block dirty");

    // a read hit returns a legal stored event type
    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_hit) |-> (o_read_kind >= KIND_W'(1) &&
                             o_read_kind <= KIND_W'(erj_pkg::MAX_KIND)))
        else $error("read hit on illegal event type");

endmodule

// ===== tb/sv/tb_event_ring_journal_check.sv =====
`timescale 1ns / 1ps
// tb_event_ring_journal_check: watches both channels of the event ring journal, keeps its own
// copy of the journal, predicts each result item and compares it field by field
// depends on erj_pkg for widths and operation codes
module tb_event_ring_journal_check
    import erj_pkg::*;
#(
    parameter int RING_DEPTH   = CAPACITY,
    parameter int BLOCK_EVENTS = EVENTS_PER_BLOCK
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SEQ_W-1:0]    i_seq_number,
    input  logic [TIME_W-1:0]   i_event_time,
    input  logic [KIND_W-1:0]   i_event_kind,
    input  logic [PARAM_W-1:0]  i_event_param,
    // result channel
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_ok,
    input  logic [TIME_W-1:0]   i_read_time,
    input  logic [KIND_W-1:0]   i_read_kind,
    input  logic [PARAM_W-1:0]  i_read_param,
    input  logic [BLOCK_W-1:0]  i_flushed_block,
    input  logic [COUNT_W-1:0]  i_stored_count,
    input  logic [SEQ_W-1:0]    i_next_seq,
    input  logic                i_work_pending,
    // verdict inputs for the top
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int BLOCKS = (RING_DEPTH + BLOCK_EVENTS - 1) / BLOCK_EVENTS;

    typedef struct packed {
        logic                ok;
        logic [TIME_W-1:0]   rtime;
        logic [KIND_W-1:0]   rkind;
        logic [PARAM_W-1:0]  rparam;
        logic [BLOCK_W-1:0]  flushed;
        logic [COUNT_W-1:0]  count;
        logic [SEQ_W-1:0]    next_seq;
        logic                pending;
    } t_journal_result;

    // private copy of the journal
    logic [TIME_W-1:0]   log_time  [RING_DEPTH];
    logic [KIND_W-1:0]   log_kind  [RING_DEPTH];
    logic [PARAM_W-1:0]  log_param [RING_DEPTH];
    logic [SEQ_W-1:0]    newest_seq;
    int unsigned         held;
    logic [BLOCKS-1:0]   dirty_map;

    t_journal_result     journal_expect_q [$];
    int                  results_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        results_seen = 0;
    end

    // sequence the journal wants next, zero once wrapped
    function automatic logic [SEQ_W-1:0] next_wanted();
        return (newest_seq == '0) ? SEQ_W'(1) : newest_seq + SEQ_W'(1);
    endfunction

    // apply one item to the journal copy and return the result it causes
    function automatic t_journal_result journal_apply(
        input logic [FUNC_W-1:0]   fn,
        input logic [SEQ_W-1:0]    seq,
        input logic [TIME_W-1:0]   tm,
        input logic [KIND_W-1:0]   kind,
        input logic [PARAM_W-1:0]  prm
    );
        t_journal_result    r;
        logic [SEQ_W-1:0]   want;
        int                 slot;
        r    = '0;
        want = next_wanted();
        case (fn)
            FUNC_APPEND: begin
                if (seq != '0 && kind >= 1 && kind <= MAX_KIND && want != '0 && seq == want) begin
                    slot = int'((seq - SEQ_W'(1)) % SEQ_W'(RING_DEPTH));
                    log_time[slot]  = tm;
                    log_kind[slot]  = kind;
                    log_param[slot] = prm;
                    newest_seq      = seq;
                    if (held < RING_DEPTH) held++;
                    if (slot / BLOCK_EVENTS < BLOCKS) dirty_map[slot / BLOCK_EVENTS] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            FUNC_READ: begin
                if (seq != '0 && held != 0 && seq <= newest_seq && (newest_seq - seq) < held) begin
                    slot = int'((seq - SEQ_W'(1)) % SEQ_W'(RING_DEPTH));
                    if (log_kind[slot] >= 1 && log_kind[slot] <= MAX_KIND) begin
                        r.ok     = 1'b1;
                        r.rtime  = log_time[slot];
                        r.rkind  = log_kind[slot];
                        r.rparam = log_param[slot];
                    end
                end
            end
            FUNC_TAKE: begin
                // lowest dirty block wins
                for (int b = 0; b < BLOCKS; b++) begin
                    if (!r.ok && dirty_map[b]) begin
                        dirty_map[b] = 1'b0;
                        r.ok         = 1'b1;
                        r.flushed    = BLOCK_W'(b);
                    end
                end
            end
            default: ;
        endcase
        r.count    = COUNT_W'(held);
        r.next_seq = next_wanted();
        r.pending  = |dirty_map;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_journal_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < RING_DEPTH; s++) begin
                log_time[s]  = '0;
                log_kind[s]  = '0;
                log_param[s] = '0;
            end
            newest_seq = '0;
            held       = 0;
            dirty_map  = '0;
            journal_expect_q.delete();
        end else begin
            // result item first: it belongs to an earlier input item
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (journal_expect_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = journal_expect_q.pop_front();
                    compare_field("ok",            i_ok,            want.ok);
                    compare_field("read_time",     i_read_time,     want.rtime);
                    compare_field("read_kind",     i_read_kind,     want.rkind);
                    compare_field("read_param",    i_read_param,    want.rparam);
                    compare_field("flushed_block", i_flushed_block, want.flushed);
                    compare_field("stored_count",  i_stored_count,  want.count);
                    compare_field("next_seq",      i_next_seq,      want.next_seq);
                    compare_field("work_pending",  i_work_pending,  want.pending);
                end
            end
            if (i_in_valid && !i_in_stall)
                journal_expect_q.push_back(journal_apply(i_func, i_seq_number, i_event_time,
                                                         i_event_kind, i_event_param));
        end
        o_pending = journal_expect_q.size();
    end

endmodule

// ===== tb/sv/tb_event_ring_journal_top.sv =====
`timescale 1ns / 1ps
// tb_event_ring_journal_top: clock, reset and stimulus for event_ring_journal_top, with random
// gaps and result stalls; depends on erj_pkg, the block and tb_event_ring_journal_check
module tb_event_ring_journal_top;
    import erj_pkg::*;

    // unused operation code, the block does nothing with it
    localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;
    localparam int RANDOM_ITEMS = 1700;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   req_func;
    logic [SEQ_W-1:0]    req_seq;
    logic [TIME_W-1:0]   req_time;
    logic [KIND_W-1:0]   req_kind;
    logic [PARAM_W-1:0]  req_param;
    logic                out_valid;
    logic                out_stall;
    logic                res_ok;
    logic [TIME_W-1:0]   res_time;
    logic [KIND_W-1:0]   res_kind;
    logic [PARAM_W-1:0]  res_param;
    logic [BLOCK_W-1:0]  res_block;
    logic [COUNT_W-1:0]  res_count;
    logic [SEQ_W-1:0]    res_next;
    logic                res_pending;
    int                  fail_count;
    int                  pending;

    // stimulus bookkeeping: next legal sequence and how many events are retained
    logic [SEQ_W-1:0]    next_append;
    int unsigned         held_events;
    bit                  gap_on;

    event_ring_journal_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (req_func),
        .i_seq_number    (req_seq),
        .i_event_time    (req_time),
        .i_event_kind    (req_kind),
        .i_event_param   (req_param),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_ok            (res_ok),
        .o_read_time     (res_time),
        .o_read_kind     (res_kind),
        .o_read_param    (res_param),
        .o_flushed_block (res_block),
        .o_stored_count  (res_count),
        .o_next_seq      (res_next),
        .o_work_pending  (res_pending)
    );

    tb_event_ring_journal_check journal_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_func          (req_func),
        .i_seq_number    (req_seq),
        .i_event_time    (req_time),
        .i_event_kind    (req_kind),
        .i_event_param   (req_param),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_ok            (res_ok),
        .i_read_time     (res_time),
        .i_read_kind     (res_kind),
        .i_read_param    (res_param),
        .i_flushed_block (res_block),
        .i_stored_count  (res_count),
        .i_next_seq      (res_next),
        .i_work_pending  (res_pending),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side stalls: short runs, a few long ones, and quiet stretches
    initial begin
        int  run;
        int  pick;
        bit  quiet;
        out_stall = 1'b0;
        run       = 0;
        quiet     = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(399) == 0) quiet = !quiet;
            if (run > 0) begin
                run--;
            end else if (quiet) begin
                out_stall = 1'b0;
            end else begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    out_stall = 1'b0;
                    run       = $urandom_range(4);
                end else if (pick < 93) begin
                    out_stall = 1'b1;
                    run       = $urandom_range(2);
                end else begin
                    out_stall = 1'b1;
                    run       = $urandom_range(30, 10);
                end
            end
        end
    end

    // present one item after a random gap and hold it until accepted
    task automatic send_item(
        input logic [FUNC_W-1:0]   fn,
        input logic [SEQ_W-1:0]    seq,
        input logic [TIME_W-1:0]   tm,
        input logic [KIND_W-1:0]   kind,
        input logic [PARAM_W-1:0]  prm
    );
        int gap;
        int pick;
        pick = $urandom_range(99);
        if (!gap_on || pick < 55) gap = 0;
        else if (pick < 90)       gap = $urandom_range(3, 1);
        else                      gap = $urandom_range(25, 6);
        repeat (gap) @(negedge i_clk);
        in_valid  = 1'b1;
        req_func  = fn;
        req_seq   = seq;
        req_time  = tm;
        req_kind  = kind;
        req_param = prm;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        in_valid = 1'b0;
        // track legal appends so later items can aim at the live window
        if (fn == FUNC_APPEND && seq == next_append && next_append != '0 &&
            kind >= 1 && kind <= MAX_KIND) begin
            next_append++;
            if (held_events < CAPACITY) held_events++;
        end
    endtask

    // mostly legal appends, reads near the live window and takes, the rest broken or noise
    task automatic random_item();
        int                 pick;
        logic [SEQ_W-1:0]   newest;
        logic [SEQ_W-1:0]   seq;
        logic [KIND_W-1:0]  bad_kind;
        pick     = $urandom_range(99);
        newest   = next_append - SEQ_W'(1);
        bad_kind = ($urandom_range(1) == 0) ? KIND_W'(0) : KIND_W'($urandom_range(255, 15));
        if (pick < 50) begin
            send_item(FUNC_APPEND, next_append, $urandom,
                      KIND_W'($urandom_range(MAX_KIND, 1)), PARAM_W'($urandom));
        end else if (pick < 58) begin
            case ($urandom_range(3))
                0: seq = $urandom;
                1: seq = next_append + SEQ_W'($urandom_range(2, 1));
                2: seq = newest;
                default: seq = '0;
            endcase
            if ($urandom_range(2) == 0)
                send_item(FUNC_APPEND, next_append, $urandom, bad_kind, PARAM_W'($urandom));
            else
                send_item(FUNC_APPEND, seq, $urandom,
                          KIND_W'($urandom_range(MAX_KIND, 1)), PARAM_W'($urandom));
        end else if (pick < 80) begin
            case ($urandom_range(4))
                0, 1: seq = (held_events == 0) ? newest
                          : newest - SEQ_W'($urandom_range(held_events - 1));
                2: seq = newest - SEQ_W'(held_events);
                3: seq = next_append;
                default: seq = $urandom;
            endcase
            send_item(FUNC_READ, seq, $urandom, KIND_W'($urandom), PARAM_W'($urandom));
        end else if (pick < 95) begin
            send_item(FUNC_TAKE, $urandom, $urandom, KIND_W'($urandom), PARAM_W'($urandom));
        end else begin
            send_item(FUNC_IDLE, $urandom, $urandom, KIND_W'($urandom), PARAM_W'($urandom));
        end
    endtask

    // stimulus and verdict
    initial begin
        in_valid    = 1'b0;
        req_func    = FUNC_APPEND;
        req_seq     = '0;
        req_time    = '0;
        req_kind    = '0;
        req_param   = '0;
        i_rst_n     = 1'b0;
        next_append = SEQ_W'(1);
        held_events = 0;
        gap_on      = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty log: read, take with nothing dirty, unused code
        send_item(FUNC_READ,   SEQ_W'(1), '0, '0, '0);
        send_item(FUNC_TAKE,   '0,        '0, '0, '0);
        send_item(FUNC_IDLE,   '1,        '1, '1, '1);
        // rejected appends: out of order, type 0 and 15, zero sequence
        send_item(FUNC_APPEND, SEQ_W'(2), TIME_W'(5), KIND_W'(1),  PARAM_W'(1));
        send_item(FUNC_APPEND, SEQ_W'(1), TIME_W'(5), KIND_W'(0),  PARAM_W'(1));
        send_item(FUNC_APPEND, SEQ_W'(1), TIME_W'(5), KIND_W'(15), PARAM_W'(1));
        send_item(FUNC_APPEND, '0,        TIME_W'(5), KIND_W'(3),  PARAM_W'(1));
        // legal appends at the field extremes
        send_item(FUNC_APPEND, SEQ_W'(1), '0, KIND_W'(1),        '0);
        send_item(FUNC_APPEND, SEQ_W'(2), '1, KIND_W'(MAX_KIND), '1);
        // duplicate sequence and type 255
        send_item(FUNC_APPEND, SEQ_W'(2), TIME_W'(9), KIND_W'(5),   PARAM_W'(7));
        send_item(FUNC_APPEND, SEQ_W'(3), TIME_W'(9), KIND_W'(255), PARAM_W'(7));
        // reads: two retained, not yet written, zero, top of range
        send_item(FUNC_READ,   SEQ_W'(1), '1, '1, '1);
        send_item(FUNC_READ,   SEQ_W'(2), '0, '0, '0);
        send_item(FUNC_READ,   SEQ_W'(3), '0, '0, '0);
        send_item(FUNC_READ,   '0,        '0, '0, '0);
        send_item(FUNC_READ,   '1,        '0, '0, '0);
        // take block 0, then nothing left
        send_item(FUNC_TAKE,   '0,        '0, '0, '0);
        send_item(FUNC_TAKE,   '0,        '0, '0, '0);
        send_item(FUNC_APPEND, SEQ_W'(3), TIME_W'(32'h8000_0001), KIND_W'(7), PARAM_W'(8'h80));
        send_item(FUNC_READ,   SEQ_W'(3), '0, '0, '0);
        send_item(FUNC_IDLE,   '0,        '0, '0, '0);

        // drain before the random part
        wait (pending == 0);
        @(negedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) gap_on = ($urandom_range(3) != 0);
            if (n % 500 == 250) begin
                wait (pending == 0);
                @(negedge i_clk);
            end
            random_item();
        end

        // wait for the last results before the verdict
        wait (pending == 0);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
